// ===== src/tse_pkg.sv =====
// Shared types and constants for the template-to-script escaper.
`default_nettype none
package tse_pkg;

  localparam int RES_MAX = 8;

  // configuration register indexes
  localparam logic [1:0] REG_OPEN_BYTES  = 2'd0;
  localparam logic [1:0] REG_OPEN_LEN    = 2'd1;
  localparam logic [1:0] REG_CLOSE_BYTES = 2'd2;
  localparam logic [1:0] REG_CLOSE_LEN   = 2'd3;

  localparam logic [31:0] OPEN_BYTES_RST  = 32'd16188;
  localparam logic [2:0]  OPEN_LEN_RST    = 3'd2;
  localparam logic [31:0] CLOSE_BYTES_RST = 32'd15935;
  localparam logic [2:0]  CLOSE_LEN_RST   = 3'd2;

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_S      = 8'h73;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } tse_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       done_res;
    logic       inside_at_end;
  } tse_res_t;

  typedef struct packed {
    logic [31:0] open_bytes;
    logic [2:0]  open_len;
    logic [31:0] close_bytes;
    logic [2:0]  close_len;
  } tse_cfg_t;

  // one item's worth of results, byte 0 goes out first
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] bytes;
    logic [3:0]              cnt;
    logic                    eos;
    logic                    inside_end;
  } tse_burst_t;

  typedef struct packed {
    logic       in_region;
    logic [1:0] match_cnt;
  } tse_state_t;

endpackage
`default_nettype wire

// ===== src/tse_emit.sv =====
// Per-item emission logic: delimiter match, escaping and next scanner state.
`default_nettype none
module tse_emit #(
  parameter int SEQ_MAX = 4
) (
  input  wire tse_pkg::tse_req_t   req,
  input  wire tse_pkg::tse_state_t state,
  input  wire tse_pkg::tse_cfg_t   cfg,
  output tse_pkg::tse_burst_t burst,
  output tse_pkg::tse_state_t state_next
);

  localparam int         CAP   = (SEQ_MAX < 4) ? SEQ_MAX : 4;
  localparam logic [2:0] CAP_L = 3'(CAP);

  logic [31:0] word;
  logic [2:0]  len_raw;
  logic [2:0]  len_eff;
  logic [7:0]  cur_delim;
  logic [1:0]  inc;
  logic        hit;
  logic        complete;
  logic        esc;
  logic [7:0]  b;

  assign b         = req.in_byte;
  assign word      = state.in_region ? cfg.close_bytes : cfg.open_bytes;
  assign len_raw   = state.in_region ? cfg.close_len : cfg.open_len;
  assign len_eff   = (len_raw == 3'd0) ? 3'd1 : ((len_raw > CAP_L) ? CAP_L : len_raw);
  assign cur_delim = word[8*state.match_cnt +: 8];
  assign hit       = (b == cur_delim);
  assign inc       = state.match_cnt + 2'd1;
  assign complete  = (inc == 2'd0) || ({1'b0, inc} >= len_eff);
  assign esc       = !state.in_region &&
                     (b == tse_pkg::CH_LBRACE || b == tse_pkg::CH_RBRACE ||
                      b == tse_pkg::CH_DOLLAR || b == tse_pkg::CH_LBRACK ||
                      b == tse_pkg::CH_RBRACK || b == tse_pkg::CH_QUOTE ||
                      b == tse_pkg::CH_BSLASH);

  always_comb begin
    burst      = '0;
    state_next = state;
    if (req.req_type == tse_pkg::REQ_EOS) begin
      burst.cnt        = 4'd1;
      burst.eos        = 1'b1;
      burst.inside_end = state.in_region;
      state_next       = '0;
    end else if (hit) begin
      if (complete) begin
        state_next.match_cnt = 2'd0;
        state_next.in_region = !state.in_region;
        if (state.in_region) begin
          burst.bytes[0] = tse_pkg::CH_NL;
          burst.bytes[1] = tse_pkg::CH_SP;
          burst.bytes[2] = tse_pkg::CH_P;
          burst.bytes[3] = tse_pkg::CH_U;
          burst.bytes[4] = tse_pkg::CH_T;
          burst.bytes[5] = tse_pkg::CH_S;
          burst.bytes[6] = tse_pkg::CH_SP;
          burst.bytes[7] = tse_pkg::CH_QUOTE;
          burst.cnt      = 4'd8;
        end else begin
          burst.bytes[0] = tse_pkg::CH_QUOTE;
          burst.bytes[1] = tse_pkg::CH_NL;
          burst.cnt      = 4'd2;
        end
      end else begin
        // partial match: hold the byte back
        state_next.match_cnt = inc;
      end
    end else begin
      // flush the matched prefix raw, then the byte itself, with a backslash before it when escaped
      state_next.match_cnt = 2'd0;
      for (int i = 0; i < tse_pkg::RES_MAX; i++) begin
        if (4'(i) < {2'b00, state.match_cnt}) begin
          burst.bytes[i] = word[8*i[1:0] +: 8];
        end else if (4'(i) == {2'b00, state.match_cnt} && esc) begin
          burst.bytes[i] = tse_pkg::CH_BSLASH;
        end else begin
          burst.bytes[i] = b;
        end
      end
      burst.cnt = {2'b00, state.match_cnt} + {3'b000, esc} + 4'd1;
    end
  end

endmodule
`default_nettype wire

// ===== src/template_to_script_escaper_unit.sv =====
// Top level of the template-to-script escaper.
// Usage:
//   Template bytes enter on the req channel (req_valid / req_stall / req_data);
//   req_type set marks end of stream. Script bytes leave on the res channel,
//   one result per transaction, with last on the final result of each item.
//   An end-of-stream item yields a single result with done_res and the
//   inside flag at that point.
// Flow:
//   An item is registered in the input register, then scanned and its results
//   loaded into an output shift register once that register is free. The output
//   register sends one result per cycle while res_stall is low, so an item with n
//   results (n from 1 to 8) occupies it until all n are taken; items with no result
//   (partial delimiter match) load nothing into it. Single-result items flow at
//   one per cycle while res_stall is low.
// Reset (rst, synchronous): delimiters return to '<?' and '?>' with length 2,
//   the scanner goes outside with no partial match, both stages empty.
// Stall: when res_stall is high the output register holds, the input register
//   fills and req_stall rises until results drain.
// Configuration writes land on any cycle with cfg_we high; issue them while idle.
`default_nettype none
module template_to_script_escaper_unit #(
  parameter int SEQ_MAX = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire tse_pkg::tse_req_t req_data,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output tse_pkg::tse_res_t      res_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  tse_pkg::tse_cfg_t   cfg;
  tse_pkg::tse_state_t state;
  tse_pkg::tse_state_t state_next;
  tse_pkg::tse_req_t   hold;
  logic                hold_valid;
  tse_pkg::tse_burst_t burst_new;

  logic [tse_pkg::RES_MAX-1:0][7:0] obytes;
  logic [3:0]                       orem;
  logic                             oeos;
  logic                             oinside;

  logic req_take;
  logic res_take;
  logic out_free;
  logic fire;

  assign res_take  = res_valid && !res_stall;
  assign out_free  = !res_valid || (res_take && orem == 4'd1);
  assign fire      = hold_valid && out_free;
  assign req_stall = hold_valid && !out_free;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_bytes  <= tse_pkg::OPEN_BYTES_RST;
      cfg.open_len    <= tse_pkg::OPEN_LEN_RST;
      cfg.close_bytes <= tse_pkg::CLOSE_BYTES_RST;
      cfg.close_len   <= tse_pkg::CLOSE_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tse_pkg::REG_OPEN_BYTES:  cfg.open_bytes  <= cfg_data;
        tse_pkg::REG_OPEN_LEN:    cfg.open_len    <= cfg_data[2:0];
        tse_pkg::REG_CLOSE_BYTES: cfg.close_bytes <= cfg_data;
        tse_pkg::REG_CLOSE_LEN:   cfg.close_len   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  tse_emit #(
    .SEQ_MAX(SEQ_MAX)
  ) u_emit (
    .req       (hold),
    .state     (state),
    .cfg       (cfg),
    .burst     (burst_new),
    .state_next(state_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_take) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      hold <= req_data;
    end
  end

  // scanner state advances when the held item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // output shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      orem      <= 4'd0;
    end else if (fire && burst_new.cnt != 4'd0) begin
      res_valid <= 1'b1;
      orem      <= burst_new.cnt;
    end else if (res_take) begin
      res_valid <= (orem != 4'd1);
      orem      <= orem - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && burst_new.cnt != 4'd0) begin
      obytes  <= burst_new.bytes;
      oeos    <= burst_new.eos;
      oinside <= burst_new.inside_end;
    end else if (res_take) begin
      obytes  <= obytes >> 8;
    end
  end

  assign res_data.out_byte      = oeos ? 8'h00 : obytes[0];
  assign res_data.byte_valid    = !oeos;
  assign res_data.last          = (orem == 4'd1);
  assign res_data.done_res      = oeos;
  assign res_data.inside_at_end = oeos && oinside;

endmodule
`default_nettype wire
